// File: src/assert_macros.svh
// Assertion helpers shared by the RTL. Each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Check that cond is never true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

// File: src/lmcs_pkg.sv
`default_nettype none
package lmcs_pkg;

   localparam int CHAIN_CHIPS_DEFAULT = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int PANEL_WIDTH         = 16;

   // Brightness: intensity = percent / 6, clamped to 15.
   localparam int MAX_INTENSITY   = 15;
   localparam int PERCENT_STEP    = 6;
   localparam int CLAMP_PERCENT   = MAX_INTENSITY * PERCENT_STEP;
   // floor(p * 43 / 256) equals p / 6 for all p below the clamp point
   localparam int RECIP_STEP      = 43;
   localparam int RECIP_SHIFT     = 8;
   localparam logic [3:0] OP_INTENSITY = 4'ha;

   // Panel layout: right panel on positions 0..3, left on 4..7.
   localparam logic [2:0] RIGHT_TOP = 3'd3;
   localparam logic [2:0] LEFT_TOP  = 3'd7;

   typedef enum logic [1:0] {
      CMD_PIXEL  = 2'd0,
      CMD_BCAST  = 2'd1,
      CMD_BRIGHT = 2'd2
   } cmd_type;

   // One unit of work for the back end: a frame pair for a pixel row byte,
   // or a set of CHAIN_CHIPS frames for a broadcast register write.
   typedef struct packed {
      logic       is_bcast;
      logic [3:0] opcode;
      logic [7:0] data_right;
      logic [7:0] data_left;
      logic [2:0] pos_right;
      logic [2:0] pos_left;
   } job_type;

endpackage
`default_nettype wire

// File: src/lmcs_front.sv
`default_nettype none
module lmcs_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire  [1:0]           req_command,
   input  wire  [7:0]           req_red,
   input  wire  [7:0]           req_green,
   input  wire  [7:0]           req_blue,
   input  wire  [3:0]           req_reg_opcode,
   input  wire  [7:0]           req_reg_value,
   input  wire  [7:0]           req_brightness_percent,
   input  wire                  csr_write_enable,
   input  wire                  csr_write_data,
   input  wire                  queue_full,
   output logic                 push,
   output lmcs_pkg::job_type    push_job
);

   logic [7:0] pos_ff, pos_in;
   logic [7:0] lit_ff, lit_in;
   logic       mirror_ff, mirror_in;

   logic        accept;
   logic        lit;
   logic [7:0]  row_byte;
   logic [1:0]  quad;
   logic [3:0]  line;
   logic [13:0] prod;
   logic [3:0]  intensity;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      lit       = |{req_red, req_green, req_blue};
      row_byte  = {lit_ff[6:0], lit};
      line      = 4'(pos_ff / lmcs_pkg::PANEL_WIDTH);
      quad      = {line[3], pos_ff[3]};
      prod      = 14'(req_brightness_percent) * 14'(lmcs_pkg::RECIP_STEP);
      intensity = (req_brightness_percent >= 8'(lmcs_pkg::CLAMP_PERCENT))
                  ? 4'(lmcs_pkg::MAX_INTENSITY) : prod[lmcs_pkg::RECIP_SHIFT +: 4];
   end

   always_comb begin
      pos_in    = pos_ff;
      lit_in    = lit_ff;
      mirror_in = csr_write_enable ? csr_write_data : mirror_ff;
      push      = 1'b0;
      push_job  = '0;
      unique case (lmcs_pkg::cmd_type'(req_command))
         lmcs_pkg::CMD_PIXEL: begin
            push_job.opcode     = {1'b0, line[2:0]} + 4'd1;
            push_job.data_right = row_byte;
            push_job.data_left  = mirror_ff ? {<<{row_byte}} : row_byte;
            push_job.pos_right  = lmcs_pkg::RIGHT_TOP - {1'b0, quad};
            push_job.pos_left   = lmcs_pkg::LEFT_TOP - {1'b0, quad ^ {1'b0, mirror_ff}};
            if (accept) begin
               pos_in = pos_ff + 8'd1;
               if (pos_ff[2:0] == 3'b111) begin
                  lit_in = '0;
                  push   = 1'b1;
               end else begin
                  lit_in = row_byte;
               end
            end
         end
         lmcs_pkg::CMD_BCAST: begin
            push_job.is_bcast   = 1'b1;
            push_job.opcode     = req_reg_opcode;
            push_job.data_right = req_reg_value;
            push                = accept;
         end
         lmcs_pkg::CMD_BRIGHT: begin
            push_job.is_bcast   = 1'b1;
            push_job.opcode     = lmcs_pkg::OP_INTENSITY;
            push_job.data_right = {4'h0, intensity};
            push                = accept;
         end
         default: begin
            // unused code: take the request and drop it
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         lit_ff    <= '0;
         mirror_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         lit_ff    <= lit_in;
         mirror_ff <= mirror_in;
      end
   end

endmodule
`default_nettype wire

// File: src/lmcs_queue.sv
`default_nettype none
module lmcs_queue #(
   parameter int DEPTH = lmcs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  lmcs_pkg::job_type    push_job,
   output logic                 full,
   input  wire                  pop,
   output logic                 job_valid,
   output lmcs_pkg::job_type    job
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   lmcs_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign job_valid = count_ff != '0;
   assign job       = entry_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// File: src/lmcs_back.sv
`default_nettype none
module lmcs_back #(
   parameter int CHAIN_CHIPS = lmcs_pkg::CHAIN_CHIPS_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  job_valid,
   input  lmcs_pkg::job_type    job,
   output logic                 pop,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic [15:0]          rsp_chain_word,
   output logic                 rsp_frame_end,
   output logic                 rsp_last
);

   localparam int SLOT_W = $clog2(CHAIN_CHIPS);
   localparam int CMP_W  = (SLOT_W > 3) ? SLOT_W : 3;

   logic [SLOT_W-1:0] word_ff, word_in, frame_ff, frame_in;
   logic              valid_ff, valid_in;
   logic [15:0]       chain_ff, chain_in;
   logic              end_ff, end_in, last_ff, last_in;

   logic              advance, word_last, frame_last, hit;
   logic [SLOT_W-1:0] slot;
   logic [CMP_W-1:0]  target;
   logic [7:0]        data;

   assign advance = !valid_ff || rsp_ready;

   always_comb begin
      word_last  = word_ff == SLOT_W'(CHAIN_CHIPS - 1);
      frame_last = job.is_bcast ? (frame_ff == SLOT_W'(CHAIN_CHIPS - 1))
                                : (frame_ff == SLOT_W'(1));
      // words go out from the far end of the chain down to position 0
      slot       = SLOT_W'(CHAIN_CHIPS - 1) - word_ff;
      if (job.is_bcast) begin
         target = CMP_W'(frame_ff);
      end else if (frame_ff == '0) begin
         target = CMP_W'(job.pos_right);
      end else begin
         target = CMP_W'(job.pos_left);
      end
      data = (job.is_bcast || frame_ff == '0) ? job.data_right : job.data_left;
      hit  = CMP_W'(slot) == target;
   end

   always_comb begin
      valid_in = valid_ff;
      chain_in = chain_ff;
      end_in   = end_ff;
      last_in  = last_ff;
      word_in  = word_ff;
      frame_in = frame_ff;
      pop      = 1'b0;
      if (advance) begin
         valid_in = job_valid;
         if (job_valid) begin
            chain_in = hit ? {4'h0, job.opcode, data} : '0;
            end_in   = word_last;
            last_in  = word_last && frame_last;
            word_in  = word_last ? '0 : word_ff + 1'b1;
            if (word_last) begin
               frame_in = frame_last ? '0 : frame_ff + 1'b1;
            end
            pop = word_last && frame_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         word_ff  <= '0;
         frame_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         word_ff  <= word_in;
         frame_ff <= frame_in;
      end
   end

   always_ff @(posedge clock) begin
      chain_ff <= chain_in;
      end_ff   <= end_in;
      last_ff  <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_chain_word = chain_ff;
   assign rsp_frame_end  = end_ff;
   assign rsp_last       = last_ff;

endmodule
`default_nettype wire

// File: src/led_matrix_chain_frame_serializer.sv
// Frame serializer for a daisy chain of CHAIN_CHIPS 8x8 LED matrix drivers
// forming two 16x16 panels (right panel on positions 0..3, left on 4..7).
// Send pixels in framebuffer order, 256 per frame; every eighth pixel closes
// a row byte and produces two chain frames of CHAIN_CHIPS words (right panel
// first). Broadcast and brightness requests produce CHAIN_CHIPS frames, chip 0
// first. rsp_frame_end marks the last word of each chain frame (release chip
// select there) and rsp_last the last word caused by one request. Write
// csr_write_data to set mirror mode only while the block is idle.
// Timing: the front end takes one request per cycle while the job queue has
// room; the back end emits one word per cycle while rsp_ready allows, so a row
// byte costs 2*CHAIN_CHIPS words and a broadcast CHAIN_CHIPS*CHAIN_CHIPS words
// of the output port. Sustained pixel throughput is therefore set by the single
// output register. With an empty queue the first word of a job passes through
// the job queue and then the output register after its request is taken.
`default_nettype none
`include "assert_macros.svh"
module led_matrix_chain_frame_serializer #(
   parameter int CHAIN_CHIPS = lmcs_pkg::CHAIN_CHIPS_DEFAULT,
   parameter int QUEUE_DEPTH = lmcs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [1:0]  req_command,
   input  wire  [7:0]  req_red,
   input  wire  [7:0]  req_green,
   input  wire  [7:0]  req_blue,
   input  wire  [3:0]  req_reg_opcode,
   input  wire  [7:0]  req_reg_value,
   input  wire  [7:0]  req_brightness_percent,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [15:0] rsp_chain_word,
   output logic        rsp_frame_end,
   output logic        rsp_last,
   input  wire         csr_write_enable,
   input  wire         csr_write_data
);

   logic              push, queue_full, pop, job_valid;
   lmcs_pkg::job_type push_job, job;

   // classify requests, track pixel position and the row byte
   lmcs_front u_front (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_command            (req_command),
      .req_red                (req_red),
      .req_green              (req_green),
      .req_blue               (req_blue),
      .req_reg_opcode         (req_reg_opcode),
      .req_reg_value          (req_reg_value),
      .req_brightness_percent (req_brightness_percent),
      .csr_write_enable       (csr_write_enable),
      .csr_write_data         (csr_write_data),
      .queue_full             (queue_full),
      .push                   (push),
      .push_job               (push_job)
   );

   // hold pending jobs so requests keep flowing while words drain
   lmcs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (pop),
      .job_valid (job_valid),
      .job       (job)
   );

   // walk frames and chain slots, one word per cycle while rsp_ready allows
   lmcs_back #(
      .CHAIN_CHIPS (CHAIN_CHIPS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (job_valid),
      .job            (job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_chain_word (rsp_chain_word),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_last       (rsp_last)
   );

   `ASSERT_NEVER(a_no_push_when_full, clock, reset, push && queue_full)
   `ASSERT_NEVER(a_no_pop_when_empty, clock, reset, pop && !job_valid)
   `ASSERT_IMPLIES(a_last_ends_frame, clock, reset, rsp_valid && rsp_last, rsp_frame_end)

endmodule
`default_nettype wire

// File: verif/led_matrix_chain_frame_serializer_tb.sv
`timescale 1ns / 100ps
module led_matrix_chain_frame_serializer_tb;

   localparam int NUM_CHIPS     = lmcs_pkg::CHAIN_CHIPS_DEFAULT;
   // Pixel requests that close no row byte leave nothing to wait for, so give
   // the block this many cycles to settle before touching the mode register.
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_AFTER    = 400;    // words seen before the long hold-off
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 3_000_000;

   // Command code 3 has no meaning; the block must drop it silently.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [3:0] reg_opcode;
      logic [7:0] reg_value;
      logic [7:0] brightness_percent;
   } pixel_req_type;

   typedef struct packed {
      logic [15:0] chain_word;
      logic        frame_end;
      logic        last;
   } panel_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = '0;
   logic [7:0]  req_red = '0;
   logic [7:0]  req_green = '0;
   logic [7:0]  req_blue = '0;
   logic [3:0]  req_reg_opcode = '0;
   logic [7:0]  req_reg_value = '0;
   logic [7:0]  req_brightness_percent = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_chain_word;
   logic        rsp_frame_end;
   logic        rsp_last;
   logic        csr_write_enable = 1'b0;
   logic        csr_write_data = 1'b0;

   // Requests waiting to be driven, and the chain words they must produce.
   pixel_req_type  pending_reqs[$];
   panel_word_type expected_words[$];
   pixel_req_type  driven_req;

   // Shadow copy of the block's state and mode register.
   logic [7:0]  pix_pos = '0;
   logic [7:0]  lit_shift = '0;
   logic        mirror_on = 1'b0;

   int reqs_queued = 0;
   int reqs_accepted = 0;
   int words_checked = 0;
   int fail_count = 0;
   int cycle_count = 0;

   int req_gap = 0;
   int req_burst = 0;
   int rsp_stall = 0;
   int rsp_burst = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   led_matrix_chain_frame_serializer uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_command            (req_command),
      .req_red                (req_red),
      .req_green              (req_green),
      .req_blue               (req_blue),
      .req_reg_opcode         (req_reg_opcode),
      .req_reg_value          (req_reg_value),
      .req_brightness_percent (req_brightness_percent),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_chain_word         (rsp_chain_word),
      .rsp_frame_end          (rsp_frame_end),
      .rsp_last               (rsp_last),
      .csr_write_enable       (csr_write_enable),
      .csr_write_data         (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Append one chain frame: words go out from the far end of the chain
   // (highest position) down to position 0; only the target slot carries data.
   function automatic void push_frame(input int target, input logic [3:0] op,
                                      input logic [7:0] data, input bit closes_request);
      panel_word_type w;
      for (int k = 0; k < NUM_CHIPS; k++) begin
         w.chain_word = (NUM_CHIPS - 1 - k == target) ? {4'h0, op, data} : 16'h0000;
         w.frame_end  = (k == NUM_CHIPS - 1);
         w.last       = closes_request && w.frame_end;
         expected_words.push_back(w);
      end
   endfunction

   function automatic logic [7:0] flip_bits(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7 - i];
      end
      return r;
   endfunction

   // Work out the chain words that one accepted request causes and update the
   // shadow state the same way the block does.
   function automatic void predict_chain_words(input pixel_req_type it);
      logic [7:0] pos;
      logic [1:0] quad;
      logic [3:0] row_op;
      logic [7:0] row_byte;
      int         level;
      pos = pix_pos;
      case (it.command)
         lmcs_pkg::CMD_PIXEL: begin
            lit_shift = {lit_shift[6:0], |{it.red, it.green, it.blue}};
            pix_pos   = pos + 8'd1;
            // Every eighth pixel closes a row byte: right panel frame first,
            // then the left panel (mirrored to the opposite half if enabled).
            if (pos[2:0] == 3'd7) begin
               quad      = {pos[7], pos[3]};
               row_op    = {1'b0, pos[6:4]} + 4'd1;
               row_byte  = lit_shift;
               lit_shift = '0;
               push_frame(int'(lmcs_pkg::RIGHT_TOP - quad), row_op, row_byte, 1'b0);
               if (mirror_on) begin
                  push_frame(int'(lmcs_pkg::LEFT_TOP - (quad ^ 2'b01)), row_op,
                             flip_bits(row_byte), 1'b1);
               end else begin
                  push_frame(int'(lmcs_pkg::LEFT_TOP - quad), row_op, row_byte, 1'b1);
               end
            end
         end
         lmcs_pkg::CMD_BCAST: begin
            for (int chip = 0; chip < NUM_CHIPS; chip++) begin
               push_frame(chip, it.reg_opcode, it.reg_value, chip == NUM_CHIPS - 1);
            end
         end
         lmcs_pkg::CMD_BRIGHT: begin
            level = int'(it.brightness_percent) / lmcs_pkg::PERCENT_STEP;
            if (level > lmcs_pkg::MAX_INTENSITY) begin
               level = lmcs_pkg::MAX_INTENSITY;
            end
            for (int chip = 0; chip < NUM_CHIPS; chip++) begin
               push_frame(chip, lmcs_pkg::OP_INTENSITY, level[7:0], chip == NUM_CHIPS - 1);
            end
         end
         default: begin
            // unused code: no words, state untouched
         end
      endcase
   endfunction

   // Idle length for either side: mostly none or short, now and then a long
   // gap, and occasional bursts with no idling at all.
   function automatic int pick_idle(inout int burst_left);
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic pixel_req_type make_req(input logic [1:0] cmd, input logic [7:0] r,
                                              input logic [7:0] g, input logic [7:0] b,
                                              input logic [3:0] op, input logic [7:0] val,
                                              input logic [7:0] pct);
      pixel_req_type it;
      it.command            = cmd;
      it.red                = r;
      it.green              = g;
      it.blue               = b;
      it.reg_opcode         = op;
      it.reg_value          = val;
      it.brightness_percent = pct;
      return it;
   endfunction

   task automatic queue_req(input pixel_req_type it);
      pending_reqs.push_back(it);
      reqs_queued++;
   endtask

   // Queue count random requests that the block acts on; dropped codes are
   // sprinkled in as noise but not counted.
   task automatic queue_random(input int count);
      pixel_req_type it;
      int            r;
      int            counted;
      counted = 0;
      while (counted < count) begin
         // Fill every field so the unused ones carry junk too.
         it = make_req(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       4'($urandom), 8'($urandom), 8'($urandom));
         r = $urandom_range(0, 99);
         if (r < 84) begin
            it.command = lmcs_pkg::CMD_PIXEL;
            if ($urandom_range(0, 99) < 40) begin
               it.red   = '0;
               it.green = '0;
               it.blue  = '0;
            end else begin
               if ($urandom_range(0, 1) == 0) it.red = '0;
               if ($urandom_range(0, 1) == 0) it.green = '0;
               if ($urandom_range(0, 1) == 0) it.blue = '0;
            end
         end else if (r < 91) begin
            it.command = lmcs_pkg::CMD_BCAST;
         end else if (r < 97) begin
            it.command = lmcs_pkg::CMD_BRIGHT;
            // Half of them near the clamp point.
            if ($urandom_range(0, 1) == 0) begin
               it.brightness_percent = 8'($urandom_range(80, 100));
            end
         end else begin
            it.command = CMD_UNUSED;
         end
         queue_req(it);
         if (it.command != CMD_UNUSED) counted++;
      end
   endtask

   // Block until every queued request is taken and every word has come back,
   // then let ignored pixel requests drain.
   task automatic wait_idle();
      while (reqs_accepted != reqs_queued || expected_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mirror(input logic m);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= m;
      mirror_on = m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Sender: record the request taken at this edge, then present the next one
   // once any gap has run out. Valid drops only after an accept.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_chain_words(driven_req);
            reqs_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               driven_req = pending_reqs.pop_front();
               req_command            <= driven_req.command;
               req_red                <= driven_req.red;
               req_green              <= driven_req.green;
               req_blue               <= driven_req.blue;
               req_reg_opcode         <= driven_req.reg_opcode;
               req_reg_value          <= driven_req.reg_value;
               req_brightness_percent <= driven_req.brightness_percent;
               req_valid              <= 1'b1;
               req_gap = pick_idle(req_burst);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off partway through so the
   // job queue fills and the block has to push back on its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!hold_done && words_checked >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_stall = pick_idle(rsp_burst);
         end
      end
   end

   // Checker: compare each word taken against the oldest expectation.
   always @(posedge clock) begin : word_check
      panel_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word: chain_word %h frame_end %b last %b",
                   rsp_chain_word, rsp_frame_end, rsp_last);
            fail_count++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_chain_word !== want.chain_word) begin
               $error("chain_word: expected %h, got %h", want.chain_word, rsp_chain_word);
               fail_count++;
            end
            if (rsp_frame_end !== want.frame_end) begin
               $error("frame_end: expected %b, got %b", want.frame_end, rsp_frame_end);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_last);
               fail_count++;
            end
         end
         words_checked++;
      end
   end

   // Hard stop if the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      write_mirror(1'b0);

      // Brightness around the divide and the clamp.
      queue_req(make_req(lmcs_pkg::CMD_BRIGHT, 8'd0, 8'd0, 8'd0, 4'd0, 8'd0, 8'd0));
      queue_req(make_req(lmcs_pkg::CMD_BRIGHT, 8'd0, 8'd0, 8'd0, 4'd0, 8'd0, 8'd5));
      queue_req(make_req(lmcs_pkg::CMD_BRIGHT, 8'd0, 8'd0, 8'd0, 4'd0, 8'd0, 8'd6));
      queue_req(make_req(lmcs_pkg::CMD_BRIGHT, 8'd0, 8'd0, 8'd0, 4'd0, 8'd0, 8'd90));
      queue_req(make_req(lmcs_pkg::CMD_BRIGHT, 8'd0, 8'd0, 8'd0, 4'd0, 8'd0, 8'd95));
      queue_req(make_req(lmcs_pkg::CMD_BRIGHT, 8'd0, 8'd0, 8'd0, 4'd0, 8'd0, 8'd96));
      queue_req(make_req(lmcs_pkg::CMD_BRIGHT, 8'd0, 8'd0, 8'd0, 4'd0, 8'd0, 8'd255));
      // Broadcast with the extreme register and value.
      queue_req(make_req(lmcs_pkg::CMD_BCAST, 8'd0, 8'd0, 8'd0, 4'd0, 8'd0, 8'd0));
      queue_req(make_req(lmcs_pkg::CMD_BCAST, 8'd0, 8'd0, 8'd0, 4'd15, 8'd255, 8'd0));
      // Unused command with everything set: drop it.
      queue_req(make_req(CMD_UNUSED, 8'hff, 8'hff, 8'hff, 4'hf, 8'hff, 8'hff));
      // First row byte: each colour alone lights a pixel; a broadcast lands
      // in the middle and must not disturb the partial byte.
      queue_req(make_req(lmcs_pkg::CMD_PIXEL, 8'd0, 8'd0, 8'd0, 4'd0, 8'd0, 8'd0));
      queue_req(make_req(lmcs_pkg::CMD_PIXEL, 8'd255, 8'd0, 8'd0, 4'd0, 8'd0, 8'd0));
      queue_req(make_req(lmcs_pkg::CMD_PIXEL, 8'd0, 8'd255, 8'd0, 4'd0, 8'd0, 8'd0));
      queue_req(make_req(lmcs_pkg::CMD_PIXEL, 8'd0, 8'd0, 8'd255, 4'd0, 8'd0, 8'd0));
      queue_req(make_req(lmcs_pkg::CMD_BCAST, 8'd0, 8'd0, 8'd0, lmcs_pkg::OP_INTENSITY,
                         8'h5a, 8'd0));
      queue_req(make_req(lmcs_pkg::CMD_PIXEL, 8'd0, 8'd0, 8'd0, 4'd0, 8'd0, 8'd0));
      queue_req(make_req(lmcs_pkg::CMD_PIXEL, 8'd1, 8'd0, 8'd0, 4'd0, 8'd0, 8'd0));
      queue_req(make_req(lmcs_pkg::CMD_PIXEL, 8'd0, 8'd0, 8'd128, 4'd0, 8'd0, 8'd0));
      queue_req(make_req(lmcs_pkg::CMD_PIXEL, 8'd255, 8'd255, 8'd255, 4'd0, 8'd0, 8'd0));

      // Random phases alternate mirror mode; pixel count runs past a full
      // frame so the position wraps.
      queue_random(130);
      wait_idle();
      write_mirror(1'b1);
      queue_random(120);
      wait_idle();
      write_mirror(1'b0);
      queue_random(50);
      wait_idle();
      write_mirror(1'b1);
      queue_random(50);
      wait_idle();

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
